// File: design/sprite_motion_integrator_assert.svh
// ----------------------------------------------------------------------------
// Sprite motion integrator assertion macros
// Concurrent checks on clk; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPRITE_MOTION_INTEGRATOR_ASSERT_SVH
`define SPRITE_MOTION_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
// check while out of reset
`define SMI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define SMI_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMI_ASSERT(name, prop, msg)
`define SMI_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: design/smi_pkg.sv
// ----------------------------------------------------------------------------
// Sprite motion integrator package
// Shared payload types, sequencer states, register indexes and constants.
// ----------------------------------------------------------------------------
package smi_pkg;

    localparam int STEP_BITS  = 16;  // fraction bits of time step and friction
    localparam int MAG_W      = 32;  // magnitude width fed to the remainder unit
    localparam int SUM_W      = 33;  // base plus displacement
    localparam int VEL_W      = 32;
    localparam int POS_W      = 28;
    localparam int HEAD_W     = 25;
    localparam int MAP_W      = 12;
    localparam int K_W        = STEP_BITS + 1;
    localparam int CFG_DATA_W = 16;
    localparam int TURN_DEG   = 360;

    localparam logic [K_W-1:0] K_ONE = K_W'(1) << STEP_BITS;

    localparam logic [STEP_BITS-1:0] TIME_STEP_RST = 16'd1092;
    localparam logic [STEP_BITS-1:0] LIN_FRIC_RST  = 16'd6554;
    localparam logic [STEP_BITS-1:0] ANG_FRIC_RST  = 16'd19661;
    localparam logic [MAP_W-1:0]     MAP_WIDTH_RST  = 12'd640;
    localparam logic [MAP_W-1:0]     MAP_HEIGHT_RST = 12'd480;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_TIME_STEP  = 3'd0;
    localparam cfg_idx_t CFG_LIN_FRIC   = 3'd1;
    localparam cfg_idx_t CFG_ANG_FRIC   = 3'd2;
    localparam cfg_idx_t CFG_MAP_WIDTH  = 3'd3;
    localparam cfg_idx_t CFG_MAP_HEIGHT = 3'd4;

    typedef struct packed {
        logic signed [VEL_W-1:0] accel_x;
        logic signed [VEL_W-1:0] accel_y;
        logic signed [VEL_W-1:0] rot_accel;
    } smi_in_t;

    typedef struct packed {
        logic [POS_W-1:0]        position_x;
        logic [POS_W-1:0]        position_y;
        logic signed [VEL_W-1:0] velocity_x;
        logic signed [VEL_W-1:0] velocity_y;
        logic [HEAD_W-1:0]       heading;
    } smi_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smi_rem_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KLIN,
        ST_KANG,
        ST_ACC,
        ST_DAMP,
        ST_DISP,
        ST_WRAP,
        ST_WAIT,
        ST_FIX,
        ST_DONE
    } smi_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_SPIN
    } smi_axis_t;

endpackage

// File: design/sprite_motion_integrator.sv
// ----------------------------------------------------------------------------
// Sprite motion integrator
// A new input is taken only in idle, once the previous tick has passed the
// 32-step remainder run on each of three axes and every multiply through the
// one shared multiplier, and its result has been loaded for output.
// Reset: async active low; motion state zero, configuration registers to defaults.
// ----------------------------------------------------------------------------
`include "sprite_motion_integrator_assert.svh"

module sprite_motion_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  smi_pkg::smi_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output smi_pkg::smi_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  smi_pkg::cfg_idx_t                   cfg_index,
    input  logic [smi_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import smi_pkg::*;

    localparam int DIV_W  = MAP_W + FRAC_BITS;
    localparam int WIDE_W = (DIV_W > SUM_W) ? DIV_W + 1 : SUM_W + 1;
    localparam logic [DIV_W-1:0] FULL_TURN = DIV_W'(TURN_DEG) << FRAC_BITS;

    // configuration
    logic [STEP_BITS-1:0] time_step_reg;
    logic [STEP_BITS-1:0] lin_fric_reg;
    logic [STEP_BITS-1:0] ang_fric_reg;
    logic [MAP_W-1:0]     map_width_reg;
    logic [MAP_W-1:0]     map_height_reg;

    // motion state
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    logic signed [VEL_W-1:0] vel_x_reg;
    logic signed [VEL_W-1:0] vel_y_reg;
    logic signed [VEL_W-1:0] spin_rate_reg;
    logic [HEAD_W-1:0]       heading_reg;

    // sequencer and working registers
    smi_state_t              state_reg, state_next;
    smi_axis_t               axis_reg, axis_next;
    logic                    phase_reg;
    smi_in_t                 in_data_reg;
    logic [K_W-1:0]          k_lin_reg;
    logic [K_W-1:0]          k_ang_reg;
    logic signed [VEL_W-1:0] v1_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    out_valid_reg;
    smi_out_t                out_data_reg;

    // control
    logic                    mul_step;
    logic                    consume;
    logic                    rem_start;
    logic                    out_load;
    logic signed [VEL_W-1:0] mul_a;
    logic [K_W-1:0]          mul_b;
    logic signed [VEL_W-1:0] prod;

    // datapath
    logic signed [VEL_W-1:0] vel_sel;
    logic signed [VEL_W-1:0] accel_sel;
    logic [POS_W-1:0]        base_sel;
    logic [MAP_W-1:0]        bound_px;
    logic [DIV_W-1:0]        divisor_sel;
    logic signed [SUM_W-1:0] acc_sum;
    logic signed [VEL_W-1:0] v1_sat;
    logic signed [SUM_W-1:0] disp_sum;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_abs;
    logic [DIV_W-1:0]        rem_val;
    smi_rem_stat_t           rem_stat;
    logic [WIDE_W-1:0]       rem_wide;
    logic [WIDE_W-1:0]       div_wide;
    logic [WIDE_W-1:0]       sum_wide;
    logic [WIDE_W-1:0]       fix_val;

    smi_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    smi_rem #(
        .DIV_W (DIV_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (sum_abs[MAG_W-1:0]),
        .divisor   (divisor_sel),
        .remainder (rem_val),
        .stat      (rem_stat)
    );

    // per-axis selection
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                vel_sel     = vel_x_reg;
                accel_sel   = in_data_reg.accel_x;
                base_sel    = pos_x_reg;
                bound_px    = map_width_reg;
                divisor_sel = {map_width_reg, {FRAC_BITS{1'b0}}};
            end
            AXIS_Y:
            begin
                vel_sel     = vel_y_reg;
                accel_sel   = in_data_reg.accel_y;
                base_sel    = pos_y_reg;
                bound_px    = map_height_reg;
                divisor_sel = {map_height_reg, {FRAC_BITS{1'b0}}};
            end
            AXIS_SPIN:
            begin
                vel_sel     = spin_rate_reg;
                accel_sel   = in_data_reg.rot_accel;
                base_sel    = POS_W'(heading_reg);
                bound_px    = map_width_reg;
                divisor_sel = FULL_TURN;
            end
            default:
            begin
                vel_sel     = '0;
                accel_sel   = '0;
                base_sel    = '0;
                bound_px    = '0;
                divisor_sel = '0;
            end
        endcase
    end

    // velocity plus acceleration step, clamped to 32 bits
    assign acc_sum = SUM_W'(vel_sel) + SUM_W'(prod);
    always_comb
    begin
        if (acc_sum[SUM_W-1] != acc_sum[SUM_W-2])
        begin
            v1_sat = acc_sum[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end
        else
        begin
            v1_sat = acc_sum[VEL_W-1:0];
        end
    end

    assign disp_sum = $signed({{(SUM_W-POS_W){1'b0}}, base_sel}) + SUM_W'(prod);
    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_abs  = sum_neg ? SUM_W'(-sum_reg) : sum_reg;

    // wrap fix-up from the remainder of the magnitude
    assign rem_wide = WIDE_W'(rem_val);
    assign div_wide = WIDE_W'(divisor_sel);
    assign sum_wide = WIDE_W'(sum_reg);

    always_comb
    begin
        if (axis_reg == AXIS_SPIN)
        begin
            if (sum_neg)
            begin
                fix_val = div_wide - rem_wide;
            end
            else if (sum_wide > div_wide)
            begin
                fix_val = rem_wide;
            end
            else
            begin
                fix_val = sum_wide;
            end
        end
        else
        begin
            if (bound_px == '0)
            begin
                fix_val = '0;
            end
            else if (sum_neg && (rem_val != '0))
            begin
                fix_val = div_wide - rem_wide;
            end
            else if (sum_neg)
            begin
                fix_val = '0;
            end
            else
            begin
                fix_val = rem_wide;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_KLIN;
                end
            end
            ST_KLIN:
            begin
                if (phase_reg)
                begin
                    state_next = ST_KANG;
                end
            end
            ST_KANG:
            begin
                if (phase_reg)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (phase_reg)
                begin
                    state_next = ST_DAMP;
                end
            end
            ST_DAMP:
            begin
                if (phase_reg)
                begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (phase_reg)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rem_stat.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = (axis_reg == AXIS_SPIN) ? ST_DONE : ST_ACC;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mul_step  = 1'b0;
        rem_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        axis_next = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                axis_next = AXIS_X;
            end
            ST_KLIN:
            begin
                mul_step = 1'b1;
                mul_a    = VEL_W'(lin_fric_reg);
                mul_b    = K_W'(time_step_reg);
            end
            ST_KANG:
            begin
                mul_step = 1'b1;
                mul_a    = VEL_W'(ang_fric_reg);
                mul_b    = K_W'(time_step_reg);
            end
            ST_ACC:
            begin
                mul_step = 1'b1;
                mul_a    = accel_sel;
                mul_b    = K_W'(time_step_reg);
            end
            ST_DAMP:
            begin
                mul_step = 1'b1;
                mul_a    = v1_reg;
                mul_b    = (axis_reg == AXIS_SPIN) ? k_ang_reg : k_lin_reg;
            end
            ST_DISP:
            begin
                mul_step = 1'b1;
                mul_a    = vel_sel;
                mul_b    = K_W'(time_step_reg);
            end
            ST_WRAP:
            begin
                rem_start = 1'b1;
            end
            ST_WAIT:
            begin
                rem_start = 1'b0;
            end
            ST_FIX:
            begin
                case (axis_reg)
                    AXIS_X:  axis_next = AXIS_Y;
                    AXIS_Y:  axis_next = AXIS_SPIN;
                    default: axis_next = AXIS_X;
                endcase
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign consume   = mul_step && phase_reg;
    assign cfg_ready = 1'b1;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= AXIS_X;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            time_step_reg  <= TIME_STEP_RST;
            lin_fric_reg   <= LIN_FRIC_RST;
            ang_fric_reg   <= ANG_FRIC_RST;
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            spin_rate_reg  <= '0;
            heading_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            phase_reg <= mul_step ? !phase_reg : 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:  time_step_reg  <= cfg_data;
                    CFG_LIN_FRIC:   lin_fric_reg   <= cfg_data;
                    CFG_ANG_FRIC:   ang_fric_reg   <= cfg_data;
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[MAP_W-1:0];
                    CFG_MAP_HEIGHT: map_height_reg <= cfg_data[MAP_W-1:0];
                    default:        time_step_reg  <= time_step_reg;
                endcase
            end

            // damped velocity lands in the axis state
            if (consume && (state_reg == ST_DAMP))
            begin
                case (axis_reg)
                    AXIS_X:  vel_x_reg     <= prod;
                    AXIS_Y:  vel_y_reg     <= prod;
                    default: spin_rate_reg <= prod;
                endcase
            end

            if (state_reg == ST_FIX)
            begin
                case (axis_reg)
                    AXIS_X:  pos_x_reg   <= fix_val[POS_W-1:0];
                    AXIS_Y:  pos_y_reg   <= fix_val[POS_W-1:0];
                    default: heading_reg <= fix_val[HEAD_W-1:0];
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (consume && (state_reg == ST_KLIN))
        begin
            k_lin_reg <= K_ONE - prod[K_W-1:0];
        end
        if (consume && (state_reg == ST_KANG))
        begin
            k_ang_reg <= K_ONE - prod[K_W-1:0];
        end
        if (consume && (state_reg == ST_ACC))
        begin
            v1_reg <= v1_sat;
        end
        if (consume && (state_reg == ST_DISP))
        begin
            sum_reg <= disp_sum;
        end
        if (out_load)
        begin
            out_data_reg.position_x <= pos_x_reg;
            out_data_reg.position_y <= pos_y_reg;
            out_data_reg.velocity_x <= vel_x_reg;
            out_data_reg.velocity_y <= vel_y_reg;
            out_data_reg.heading    <= heading_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SMI_ASSERT(a_rem_start_idle, rem_start |-> !rem_stat.busy, "remainder restarted while busy")
    `SMI_ASSERT(a_rem_done_wait, rem_stat.done |-> (state_reg == ST_WAIT), "remainder done outside wait")
    `SMI_ASSERT(a_accept_busy, (in_valid && in_ready) |=> !in_ready, "ready held after transaction")
    `SMI_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> (!out_valid && (state_reg == ST_IDLE)), "not idle in reset")

endmodule

// File: design/smi_mul.sv
// ----------------------------------------------------------------------------
// Sprite motion integrator multiplier
// Signed 32 x unsigned 17 product, floored by the step fraction, registered.
// ----------------------------------------------------------------------------
module smi_mul (
    input  logic                               clk,
    input  logic signed [smi_pkg::VEL_W-1:0]   op_a,
    input  logic [smi_pkg::K_W-1:0]            op_b,
    output logic signed [smi_pkg::VEL_W-1:0]   prod
);
    import smi_pkg::*;

    localparam int PROD_W = VEL_W + K_W + 1;

    logic signed [PROD_W-1:0] full_prod;
    logic signed [VEL_W-1:0]  prod_reg;

    // arithmetic shift right gives the floor
    assign full_prod = op_a * $signed({1'b0, op_b});

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[STEP_BITS+VEL_W-1:STEP_BITS];
    end

    assign prod = prod_reg;

endmodule

// File: design/smi_rem.sv
// ----------------------------------------------------------------------------
// Sprite motion integrator remainder unit
// Restoring shift-subtract remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module smi_rem #(
    parameter int DIV_W = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smi_pkg::MAG_W-1:0]    dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic [DIV_W-1:0]             remainder,
    output smi_pkg::smi_rem_stat_t       stat
);
    import smi_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
